>>> rtl/lcpf_pkg.sv
// Shared widths, constants and register codes of the Lennard-Jones plus Coulomb pair force block.
package lcpf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CW   = 32;
    localparam int DW   = CW + 1;
    localparam int NW   = 2 * DW;
    localparam int RW   = DW + 1;
    localparam int VW   = 62;
    localparam int QIW  = 64;
    localparam int EW   = CW + 5;
    localparam int OW   = 48;
    localparam int TOTW = 64;
    localparam int QML  = 3;

    localparam logic [VW-1:0] VAL_CAP = {1'b1, {(VW - 1){1'b0}}};

    localparam logic signed [TOTW-1:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [TOTW-1:0] OUT_MIN = -64'sh0000_8000_0000_0000;

    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LJ_CUTOFF = 2'd0,
        REG_CL_CUTOFF = 2'd1,
        REG_CL_SCALE  = 2'd2
    } t_reg_idx;

    localparam logic [CW-1:0] LJ_CUTOFF_RST = 32'd786432;
    localparam logic [CW-1:0] CL_CUTOFF_RST = 32'd786432;
    localparam logic [CW-1:0] CL_SCALE_RST  = 32'd21762037;

endpackage

>>> rtl/lcpf_delay.sv
// Enabled shift-register delay line of configurable width and length.
module lcpf_delay import lcpf_pkg::*; #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    generate
        if (N == 0) begin : g_none
            assign o_d = i_d;
        end else begin : g_line
            logic [W-1:0] r_tap [N];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_tap[0] <= i_d;
                    for (int k = 1; k < N; k++) begin
                        r_tap[k] <= r_tap[k-1];
                    end
                end
            end
            assign o_d = r_tap[N-1];
        end
    endgenerate

endmodule

>>> rtl/lcpf_qmul.sv
// Pipelined fixed-point product floor(a*b/2^F) clamped to the intermediate cap.
module lcpf_qmul import lcpf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [QIW-1:0] i_a,
    input  logic [QIW-1:0] i_b,
    output logic [VW-1:0]  o_p
);

    localparam int HW = QIW / 2;
    localparam int PW = 2 * QIW;

    logic [QIW-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [PW-1:0]  r_sum;
    logic [PW-1:0]  n_shift;
    logic [VW-1:0]  r_p;

    assign n_shift = r_sum >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= QIW'(i_a[HW-1:0]) * QIW'(i_b[HW-1:0]);
            r_p01 <= QIW'(i_a[HW-1:0]) * QIW'(i_b[QIW-1:HW]);
            r_p10 <= QIW'(i_a[QIW-1:HW]) * QIW'(i_b[HW-1:0]);
            r_p11 <= QIW'(i_a[QIW-1:HW]) * QIW'(i_b[QIW-1:HW]);
            r_sum <= PW'(r_p00) + (PW'(r_p01) << HW) + (PW'(r_p10) << HW) + {r_p11, {QIW{1'b0}}};
            r_p   <= (n_shift > PW'(VAL_CAP)) ? VAL_CAP : n_shift[VW-1:0];
        end
    end

    assign o_p = r_p;

endmodule

>>> rtl/lcpf_qdiv.sv
// Pipelined restoring divider floor(a*2^F/den), one quotient bit per stage, clamped to the cap.
module lcpf_qdiv import lcpf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WA        = VW,
    parameter int WQ        = VW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [WA-1:0] i_a,
    input  logic [RW-1:0] i_den,
    output logic [VW-1:0] o_q,
    output logic [RW-1:0] o_den
);

    localparam int WN = WA + FRAC_BITS;
    localparam int WX = WN + 1;
    localparam int WM = (WX > RW) ? WX : RW;

    logic [WN-1:0] w_num;
    logic [WX-1:0] w_hi;

    logic [RW-1:0] r_rem [WQ];
    logic [WQ-1:0] r_nq  [WQ+1];
    logic          r_ovf [WQ+1];
    logic [RW-1:0] r_dd  [WQ+1];

    logic [RW:0]   n_cat [1:WQ];
    logic          n_ge  [1:WQ];
    logic [RW:0]   n_sub [1:WQ-1];
    logic [RW-1:0] n_rem [1:WQ-1];

    logic          w_sat;
    logic [VW-1:0] r_q;
    logic [RW-1:0] r_dout;

    assign w_num = {i_a, {FRAC_BITS{1'b0}}};
    assign w_hi  = {1'b0, w_num} >> WQ;

    always_comb begin
        for (int j = 1; j <= WQ; j++) begin
            n_cat[j] = {r_rem[j-1], r_nq[j-1][WQ-1]};
            n_ge[j]  = n_cat[j] >= {1'b0, r_dd[j-1]};
        end
        for (int j = 1; j < WQ; j++) begin
            n_sub[j] = n_cat[j] - {1'b0, r_dd[j-1]};
            n_rem[j] = n_ge[j] ? n_sub[j][RW-1:0] : n_cat[j][RW-1:0];
        end
    end

    assign w_sat = r_ovf[WQ] || (64'(r_nq[WQ]) > 64'(VAL_CAP));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_hi[RW-1:0];
            r_nq[0]  <= w_num[WQ-1:0];
            r_ovf[0] <= WM'(w_hi) >= WM'(i_den);
            r_dd[0]  <= i_den;
            for (int j = 1; j <= WQ; j++) begin
                r_nq[j]  <= {r_nq[j-1][WQ-2:0], n_ge[j]};
                r_ovf[j] <= r_ovf[j-1];
                r_dd[j]  <= r_dd[j-1];
            end
            for (int j = 1; j < WQ; j++) begin
                r_rem[j] <= n_rem[j];
            end
            r_q    <= w_sat ? VAL_CAP : VW'(r_nq[WQ]);
            r_dout <= r_dd[WQ];
        end
    end

    assign o_q   = r_q;
    assign o_den = r_dout;

endmodule

>>> rtl/lcpf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module lcpf_isqrt import lcpf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_n,
    output logic [RW-1:0] o_root
);

    localparam int TW = 2 * RW + 1;

    logic [NW-1:0] r_rem [RW];
    logic [RW-1:0] r_res [RW];
    logic [NW-1:0] w_src_rem [RW];
    logic [RW-1:0] w_src_res [RW];
    logic [TW-1:0] w_trial [RW];
    logic          w_fit [RW];

    always_comb begin
        w_src_rem[0] = i_n;
        w_src_res[0] = '0;
        for (int s = 1; s < RW; s++) begin
            w_src_rem[s] = r_rem[s-1];
            w_src_res[s] = r_res[s-1];
        end
        for (int s = 0; s < RW; s++) begin
            w_trial[s] = (TW'(w_src_res[s]) << (RW - s)) | (TW'(1) << (2 * (RW - 1 - s)));
            w_fit[s]   = w_trial[s] <= TW'(w_src_rem[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < RW; s++) begin
                r_rem[s] <= w_fit[s] ? NW'(TW'(w_src_rem[s]) - w_trial[s]) : w_src_rem[s];
                r_res[s] <= w_fit[s] ? (w_src_res[s] | (RW'(1) << (RW - 1 - s))) : w_src_res[s];
            end
        end
    end

    assign o_root = r_res[RW-1];

endmodule

>>> rtl/lj_coulomb_pair_force.sv
// Lennard-Jones plus Coulomb pair force: one particle pair in, one saturated force vector out.
//
// Fully pipelined: a new pair can be taken every cycle while the output is not stalled.
// The pipeline depth is set by the bit-per-stage square root (34 stages) and the chains
// of restoring dividers, one quotient bit per stage, that form sigma/r and the
// divisions by r of the Lennard-Jones and Coulomb magnitudes. While a result is
// held by a stalled output the whole pipeline holds, and o_stall is raised.
// Configuration registers are plain writes; a write also affects pairs already in the
// pipeline that have not yet reached the stage that reads that register.
module lj_coulomb_pair_force import lcpf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_first_x,
    input  logic signed [CW-1:0] i_first_y,
    input  logic signed [CW-1:0] i_first_z,
    input  logic signed [CW-1:0] i_second_x,
    input  logic signed [CW-1:0] i_second_y,
    input  logic signed [CW-1:0] i_second_z,
    input  logic        [CW-1:0] i_well_depth,
    input  logic        [CW-1:0] i_contact_radius,
    input  logic signed [CW-1:0] i_first_charge,
    input  logic signed [CW-1:0] i_second_charge,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [OW-1:0] o_force_x,
    output logic signed [OW-1:0] o_force_y,
    output logic signed [OW-1:0] o_force_z,
    output logic                 o_lj_active,
    output logic                 o_coulomb_active,
    output logic                 o_saturated,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [CW-1:0]        i_cfg_wdata
);

    localparam int K_PRE = 2;
    localparam int K_N   = 4;
    localparam int K_R   = K_N + RW;
    localparam int K_KQ  = K_PRE + 2 * QML;
    localparam int WQ_T  = CW + FRAC_BITS;
    localparam int WQ_U  = FRAC_BITS + 1;
    localparam int K_T   = K_R + WQ_T + 2;
    localparam int K_U   = K_R + WQ_U + 2;
    localparam int K_M   = K_T + 4 * QML + 1;
    localparam int K_P   = K_M + QML;
    localparam int K_HL  = K_P + VW + 2;
    localparam int K_C1  = K_R + VW + 2;
    localparam int K_HC  = K_C1 + VW + 2;
    localparam int K_H   = (K_HL > K_HC) ? K_HL : K_HC;
    localparam int K_F   = K_H + QML;
    localparam int LAT   = K_F + 2;

    logic          w_adv;
    logic [LAT-1:0] r_vld;

    logic [CW-1:0] r_lj_cut, r_cl_cut, r_cl_scale;

    logic [CW-1:0] r_first [3];
    logic [CW-1:0] r_second [3];
    logic [CW-1:0] r_eps, r_sig, r_q1, r_q2;

    logic [DW-1:0] n_d [3];
    logic [DW-1:0] r_ad [3];
    logic [2:0]    r_dneg;
    logic [CW-1:0] r_aq1, r_aq2, r_sig2;
    logic          r_clneg;
    logic [EW-1:0] r_eps24;

    logic [NW-1:0] r_sq [3];
    logic [NW-1:0] r_n;

    logic [RW-1:0] w_root;
    logic          w_lj_on, w_cl_on;

    logic [VW-1:0] w_qq, w_kq, w_kq_d;
    logic [CW-1:0] w_sig_d;
    logic [VW-1:0] w_t, w_t2, w_t2_d, w_t4, w_t6, w_t6_d, w_t12;
    logic [RW-1:0] w_t_den, w_r_p;
    logic [VW:0]   w_two;
    logic [VW:0]   r_m;
    logic          r_ljneg;
    logic [EW-1:0] w_eps_d;
    logic [VW-1:0] w_p, w_hl, w_hl_d;
    logic [VW-1:0] w_c1, w_hc, w_hc_d;
    logic [RW-1:0] w_c1_den;

    logic [DW-1:0] w_ad_d [3];
    logic [VW-1:0] w_u [3];
    logic [VW-1:0] w_u_d [3];
    logic [VW-1:0] w_fl [3];
    logic [VW-1:0] w_fc [3];

    logic          w_ljneg_d;
    logic [3:0]    w_sgn_d;
    logic [1:0]    w_flags_d;

    logic signed [TOTW-1:0] n_tl [3];
    logic signed [TOTW-1:0] n_tc [3];
    logic signed [TOTW-1:0] r_tot [3];
    logic                   r_lj_s, r_cl_s;

    logic                   n_hi [3];
    logic                   n_lo [3];
    logic signed [OW-1:0]   r_force [3];
    logic                   r_lj_o, r_cl_o, r_sat;

    assign w_adv   = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lj_cut   <= LJ_CUTOFF_RST;
            r_cl_cut   <= CL_CUTOFF_RST;
            r_cl_scale <= CL_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LJ_CUTOFF: r_lj_cut   <= i_cfg_wdata;
                REG_CL_CUTOFF: r_cl_cut   <= i_cfg_wdata;
                REG_CL_SCALE:  r_cl_scale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d[i] = {r_second[i][CW-1], r_second[i]} - {r_first[i][CW-1], r_first[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_first[0]  <= i_first_x;
            r_first[1]  <= i_first_y;
            r_first[2]  <= i_first_z;
            r_second[0] <= i_second_x;
            r_second[1] <= i_second_y;
            r_second[2] <= i_second_z;
            r_eps       <= i_well_depth;
            r_sig       <= i_contact_radius;
            r_q1        <= i_first_charge;
            r_q2        <= i_second_charge;

            for (int i = 0; i < 3; i++) begin
                r_ad[i]   <= n_d[i][DW-1] ? -n_d[i] : n_d[i];
                r_dneg[i] <= n_d[i][DW-1];
                r_sq[i]   <= NW'(r_ad[i]) * NW'(r_ad[i]);
            end
            r_aq1   <= r_q1[CW-1] ? -r_q1 : r_q1;
            r_aq2   <= r_q2[CW-1] ? -r_q2 : r_q2;
            r_clneg <= r_q1[CW-1] ^ r_q2[CW-1];
            r_eps24 <= {r_eps, 4'b0} + {1'b0, r_eps, 3'b0};
            r_sig2  <= r_sig;

            r_n <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    lcpf_isqrt u_isqrt (
        .i_clk (i_clk), .i_en (w_adv), .i_n (r_n), .o_root (w_root)
    );

    assign w_lj_on = (w_root != '0) && (w_root <= RW'(r_lj_cut));
    assign w_cl_on = (w_root != '0) && (w_root <= RW'(r_cl_cut));

    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_qq (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(r_aq1)), .i_b (QIW'(r_aq2)), .o_p (w_qq)
    );
    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_kq (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(r_cl_scale)), .i_b (QIW'(w_qq)), .o_p (w_kq)
    );
    lcpf_delay #(.W(VW), .N(K_R - K_KQ)) u_kq_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_kq), .o_d (w_kq_d)
    );
    lcpf_delay #(.W(CW), .N(K_R - K_PRE)) u_sig_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (r_sig2), .o_d (w_sig_d)
    );

    lcpf_qdiv #(.FRAC_BITS(FRAC_BITS), .WA(CW), .WQ(WQ_T)) u_tdiv (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_sig_d), .i_den (w_root),
        .o_q (w_t), .o_den (w_t_den)
    );

    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_t2 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_t)), .i_b (QIW'(w_t)), .o_p (w_t2)
    );
    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_t4 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_t2)), .i_b (QIW'(w_t2)), .o_p (w_t4)
    );
    lcpf_delay #(.W(VW), .N(QML)) u_t2_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_t2), .o_d (w_t2_d)
    );
    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_t6 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_t4)), .i_b (QIW'(w_t2_d)), .o_p (w_t6)
    );
    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_t12 (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_t6)), .i_b (QIW'(w_t6)), .o_p (w_t12)
    );
    lcpf_delay #(.W(VW), .N(QML)) u_t6_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_t6), .o_d (w_t6_d)
    );

    assign w_two = {w_t12, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ljneg <= w_two < (VW + 1)'(w_t6_d);
            r_m     <= (w_two < (VW + 1)'(w_t6_d)) ? (VW + 1)'(w_t6_d) - w_two
                                                   : w_two - (VW + 1)'(w_t6_d);
        end
    end

    lcpf_delay #(.W(EW), .N(K_M - K_PRE)) u_eps_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (r_eps24), .o_d (w_eps_d)
    );
    lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_p (
        .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_eps_d)), .i_b (QIW'(r_m)), .o_p (w_p)
    );
    lcpf_delay #(.W(RW), .N(K_P - K_T)) u_rp_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_t_den), .o_d (w_r_p)
    );
    lcpf_qdiv #(.FRAC_BITS(FRAC_BITS), .WA(VW), .WQ(VW)) u_hldiv (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_p), .i_den (w_r_p),
        .o_q (w_hl), .o_den ()
    );

    lcpf_qdiv #(.FRAC_BITS(FRAC_BITS), .WA(VW), .WQ(VW)) u_c1div (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_kq_d), .i_den (w_root),
        .o_q (w_c1), .o_den (w_c1_den)
    );
    lcpf_qdiv #(.FRAC_BITS(FRAC_BITS), .WA(VW), .WQ(VW)) u_c2div (
        .i_clk (i_clk), .i_en (w_adv), .i_a (w_c1), .i_den (w_c1_den),
        .o_q (w_hc), .o_den ()
    );

    lcpf_delay #(.W(VW), .N(K_H - K_HL)) u_hl_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_hl), .o_d (w_hl_d)
    );
    lcpf_delay #(.W(VW), .N(K_H - K_HC)) u_hc_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (w_hc), .o_d (w_hc_d)
    );

    generate
        for (genvar a = 0; a < 3; a++) begin : g_axis
            lcpf_delay #(.W(DW), .N(K_R - K_PRE)) u_ad_dly (
                .i_clk (i_clk), .i_en (w_adv), .i_d (r_ad[a]), .o_d (w_ad_d[a])
            );
            lcpf_qdiv #(.FRAC_BITS(FRAC_BITS), .WA(DW), .WQ(WQ_U)) u_udiv (
                .i_clk (i_clk), .i_en (w_adv), .i_a (w_ad_d[a]), .i_den (w_root),
                .o_q (w_u[a]), .o_den ()
            );
            lcpf_delay #(.W(VW), .N(K_H - K_U)) u_u_dly (
                .i_clk (i_clk), .i_en (w_adv), .i_d (w_u[a]), .o_d (w_u_d[a])
            );
            lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_fl (
                .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_hl_d)), .i_b (QIW'(w_u_d[a])),
                .o_p (w_fl[a])
            );
            lcpf_qmul #(.FRAC_BITS(FRAC_BITS)) u_fc (
                .i_clk (i_clk), .i_en (w_adv), .i_a (QIW'(w_hc_d)), .i_b (QIW'(w_u_d[a])),
                .o_p (w_fc[a])
            );
        end
    endgenerate

    lcpf_delay #(.W(1), .N(K_F - K_M)) u_ljneg_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d (r_ljneg), .o_d (w_ljneg_d)
    );
    lcpf_delay #(.W(4), .N(K_F - K_PRE)) u_sgn_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d ({r_clneg, r_dneg}), .o_d (w_sgn_d)
    );
    lcpf_delay #(.W(2), .N(K_F - K_R)) u_flag_dly (
        .i_clk (i_clk), .i_en (w_adv), .i_d ({w_cl_on, w_lj_on}), .o_d (w_flags_d)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tl[i] = (w_ljneg_d ^ w_sgn_d[i]) ? -$signed(TOTW'(w_fl[i])) : $signed(TOTW'(w_fl[i]));
            n_tc[i] = (w_sgn_d[3] ^ w_sgn_d[i]) ? -$signed(TOTW'(w_fc[i])) : $signed(TOTW'(w_fc[i]));
            n_hi[i] = r_tot[i] > OUT_MAX;
            n_lo[i] = r_tot[i] < OUT_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_tot[i] <= (w_flags_d[0] ? n_tl[i] : '0) + (w_flags_d[1] ? n_tc[i] : '0);
                r_force[i] <= n_hi[i] ? OUT_MAX[OW-1:0] :
                              n_lo[i] ? OUT_MIN[OW-1:0] : r_tot[i][OW-1:0];
            end
            r_lj_s <= w_flags_d[0];
            r_cl_s <= w_flags_d[1];
            r_lj_o <= r_lj_s;
            r_cl_o <= r_cl_s;
            r_sat  <= n_hi[0] || n_lo[0] || n_hi[1] || n_lo[1] || n_hi[2] || n_lo[2];
        end
    end

    assign o_force_x        = r_force[0];
    assign o_force_y        = r_force[1];
    assign o_force_z        = r_force[2];
    assign o_lj_active      = r_lj_o;
    assign o_coulomb_active = r_cl_o;
    assign o_saturated      = r_sat;

`ifndef ASSERT_OFF
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_force_x == OUT_MAX[OW-1:0] || o_force_x == OUT_MIN[OW-1:0] ||
            o_force_y == OUT_MAX[OW-1:0] || o_force_y == OUT_MIN[OW-1:0] ||
            o_force_z == OUT_MAX[OW-1:0] || o_force_z == OUT_MIN[OW-1:0])
        else $error("saturated flag without a clamped component");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_lj_active && !o_coulomb_active |->
            o_force_x == '0 && o_force_y == '0 && o_force_z == '0 && !o_saturated)
        else $error("nonzero force with both terms off");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT-1] && i_stall |=> $stable(r_vld))
        else $error("pipeline moved while output stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("transfer not captured");
`endif

endmodule
